/* rtl/bms_pkg.sv */
// Shared types and constants for the boolean matrix squarer.
package bms_pkg;

  localparam int RowW  = 16;
  localparam int IdxW  = 4;
  localparam int SizeW = 5;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SQUARE = 1'b1;

  localparam logic [SizeW-1:0] SIZE_RESET = 5'd16;

  typedef struct packed {
    logic            command;
    logic [IdxW-1:0] row_index;
    logic [RowW-1:0] row_bits;
  } bms_in_t;

  typedef struct packed {
    logic [IdxW-1:0] out_row_index;
    logic [RowW-1:0] out_row_bits;
    logic            last_row;
  } bms_out_t;

  // row travelling along the cell ring, tagged with its row number
  typedef struct packed {
    logic [RowW-1:0] bits;
    logic [IdxW-1:0] idx;
  } bms_pass_t;

  typedef struct packed {
    logic            load_en;
    logic [IdxW-1:0] load_idx;
    logic [RowW-1:0] load_bits;
    logic            start;
    logic            step;
    logic            commit;
    logic [IdxW-1:0] n_m1;
    logic [RowW-1:0] colmask;
  } bms_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } bms_state_e;

endpackage

/* rtl/bms_cell.sv */
// One matrix row cell: holds its row, a ring stage and a product accumulator.
module bms_cell import bms_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk_i,
  input  bms_ctrl_t       ctrl_i,
  input  bms_pass_t       nbr_i,
  output bms_pass_t       pass_o,
  output logic [RowW-1:0] row_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);

  logic [RowW-1:0] row_q;
  logic [RowW-1:0] acc_q, acc_d;
  bms_pass_t       pass_q;
  logic            active;

  assign active = (MyIdx <= ctrl_i.n_m1);
  // row i picks up row k when its own bit k is set
  assign acc_d  = acc_q | (row_q[pass_q.idx] ? pass_q.bits : '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en && (ctrl_i.load_idx == MyIdx)) begin
      row_q <= ctrl_i.load_bits;
    end else if (ctrl_i.commit && active) begin
      row_q <= acc_d & ctrl_i.colmask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      pass_q <= '{bits: row_q, idx: MyIdx};
      acc_q  <= '0;
    end else if (ctrl_i.step) begin
      pass_q <= nbr_i;
      acc_q  <= acc_d;
    end
  end

  assign pass_o = pass_q;
  assign row_o  = row_q;

endmodule

/* rtl/bms_ctrl.sv */
// Sequencer: size register, load and square control, row emission register.
module bms_ctrl import bms_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SizeW-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bms_in_t               in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bms_out_t              out_word_o,
  input  logic [RowW-1:0]       rows_i [DEPTH],
  output bms_ctrl_t             ctrl_o
);

  bms_state_e       state_q, state_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [SizeW-1:0] size_q;
  logic [SizeW-1:0] eff, eff_m1;
  logic [IdxW-1:0]  n_m1;
  logic             out_valid_q, out_valid_d;
  bms_out_t         out_q, out_d;
  logic             out_free;
  logic             in_acc;
  logic             last_cnt;
  logic [RowW-1:0]  sel_row;

  always_comb begin
    if (size_q == '0) begin
      eff = SizeW'(1);
    end else if (size_q > SizeW'(DEPTH)) begin
      eff = SizeW'(DEPTH);
    end else begin
      eff = size_q;
    end
  end

  assign eff_m1   = eff - SizeW'(1);
  assign n_m1     = eff_m1[IdxW-1:0];
  assign last_cnt = (cnt_q == n_m1);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_acc   = in_valid_i && in_ready_o;

  always_comb begin
    sel_row = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cnt_q == IdxW'(i)) begin
        sel_row = rows_i[i];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_word_i.command == CMD_SQUARE)) begin
          state_d = ST_CALC;
          cnt_d   = '0;
        end
      end
      ST_CALC: begin
        if (last_cnt) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (last_cnt) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    ctrl_o            = '0;
    ctrl_o.n_m1       = n_m1;
    ctrl_o.colmask    = ~({RowW{1'b1}} << eff);
    ctrl_o.load_idx   = in_word_i.row_index;
    ctrl_o.load_bits  = in_word_i.row_bits;
    out_valid_d       = out_valid_q && !out_ready_i;
    out_d             = out_q;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.load_en = in_acc && (in_word_i.command == CMD_LOAD);
        ctrl_o.start   = in_acc && (in_word_i.command == CMD_SQUARE);
      end
      ST_CALC: begin
        ctrl_o.step   = 1'b1;
        ctrl_o.commit = last_cnt;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_row_index: cnt_q, out_row_bits: sel_row,
                          last_row: last_cnt};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      size_q      <= SIZE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_commit_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.commit |-> (state_q == ST_CALC) && last_cnt)
    else $error("commit away from last step");

  a_calc_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |=> (state_q == ST_CALC) || (state_q == ST_EMIT))
    else $error("illegal exit from calc");

  a_square_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_word_i.command == CMD_SQUARE)) |=> (state_q == ST_CALC))
    else $error("square word did not start calc");

  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && out_free && last_cnt)
      |=> out_valid_o && out_word_o.last_row && (state_q == ST_IDLE))
    else $error("last row not marked");

endmodule

/* rtl/boolean_matrix_squarer_top.sv */
// Top level of the boolean matrix squarer: sequencer and ring of row cells.
//
//   channel  dir  handshake             word
//   cfg      in   cfg_we_i              cfg_wdata_i (size_in_use)
//   in       in   in_valid_i/in_ready_o in_word_i (command, row_index, row_bits)
//   out      out  out_valid_o/out_ready_i out_word_o (row index, row bits, last)
//
// A load word writes one row. A square word rotates the ring once per row k
// of the old matrix, then emits the n rows in use (n = size in use). The
// emission register stalls on out_ready_i. After reset the size is 16; rows
// are undefined until loaded.
module boolean_matrix_squarer_top import bms_pkg::*; #(
  parameter int MAX_VERTICES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bms_in_t          in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bms_out_t         out_word_o
);

  localparam int Depth = (MAX_VERTICES < RowW) ? MAX_VERTICES : RowW;

  bms_ctrl_t       ctrl;
  bms_pass_t       pass [Depth];
  bms_pass_t       nbr  [Depth];
  logic [RowW-1:0] rows [Depth];

  bms_ctrl #(
    .DEPTH(Depth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .rows_i     (rows),
    .ctrl_o     (ctrl)
  );

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    // ring closes at the last row in use
    if (g == Depth - 1) begin : g_tail
      assign nbr[g] = pass[0];
    end else begin : g_body
      assign nbr[g] = (ctrl.n_m1 == IdxW'(g)) ? pass[0] : pass[g+1];
    end

    bms_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .ctrl_i(ctrl),
      .nbr_i (nbr[g]),
      .pass_o(pass[g]),
      .row_o (rows[g])
    );
  end

endmodule

/* test/bms_checker.sv */
// Checker for the boolean matrix squarer: watches the channels, predicts each squared row, compares.
module bms_checker import bms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  bms_in_t          in_word_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  bms_out_t         out_word_i,
  output int               pending_o,
  output int               mismatches_o
);

  localparam int MaxRows = 16;

  logic [RowW-1:0]  adj_rows [MaxRows];
  logic [SizeW-1:0] size_q;
  bms_out_t         rows_due [$];
  int               mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic int rows_in_use(logic [SizeW-1:0] s);
    if (s == '0) return 1;
    if (s > MaxRows) return MaxRows;
    return int'(s);
  endfunction

  task automatic report_mismatch(string what, logic [RowW-1:0] got, logic [RowW-1:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // square the held matrix in place and queue the rows it will emit
  task automatic square_and_queue();
    int              n;
    logic [RowW-1:0] colmask;
    logic [RowW-1:0] prod [MaxRows];
    bms_out_t        row_out;
    n = rows_in_use(size_q);
    colmask = RowW'((17'd1 << n) - 17'd1);
    for (int i = 0; i < n; i++) begin
      prod[i] = '0;
      for (int k = 0; k < n; k++) begin
        if (adj_rows[i][k]) prod[i] |= adj_rows[k] & colmask;
      end
    end
    for (int i = 0; i < n; i++) begin
      adj_rows[i] = prod[i];
      row_out.out_row_index = IdxW'(i);
      row_out.out_row_bits  = prod[i];
      row_out.last_row      = (i == n - 1);
      rows_due.push_back(row_out);
    end
  endtask

  task automatic check_row(bms_out_t got);
    bms_out_t want;
    if (rows_due.size() == 0) begin
      report_mismatch("word with nothing due, row bits", got.out_row_bits, 'x);
    end else begin
      want = rows_due.pop_front();
      if (got.out_row_index !== want.out_row_index)
        report_mismatch("row index", RowW'(got.out_row_index), RowW'(want.out_row_index));
      if (got.out_row_bits !== want.out_row_bits)
        report_mismatch("row bits", got.out_row_bits, want.out_row_bits);
      if (got.last_row !== want.last_row)
        report_mismatch("last row flag", RowW'(got.last_row), RowW'(want.last_row));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q = SIZE_RESET;
      foreach (adj_rows[i]) adj_rows[i] = '0;
      rows_due.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_row(out_word_i);
      if (cfg_we_i) size_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (in_word_i.command == CMD_LOAD) begin
          adj_rows[in_word_i.row_index] = in_word_i.row_bits;
        end else begin
          square_and_queue();
        end
      end
      pending_o <= rows_due.size();
    end
  end

endmodule

/* test/testbench.sv */
// Testbench top for the boolean matrix squarer: clock, reset, stimulus and verdict.
module testbench;
  import bms_pkg::*;

  localparam int MaxRows     = 16;
  localparam int StallLimit  = 3000;
  localparam int IdleCycles  = 40;
  localparam int DrainCycles = 60;
  localparam int RandomItems = 300;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [SizeW-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  bms_in_t          in_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  bms_out_t         out_word;

  int               pending;
  int               mismatches;
  int               quiet_cycles = 0;
  int               burst_left = 0;
  int               items_sent = 0;
  int               first_random = 0;
  int               rows_now = 16;
  logic [MaxRows-1:0] loaded_rows = '0;
  int               stall_mode = 0;
  int               mode_left = 0;

  boolean_matrix_squarer_top #(
    .MAX_VERTICES(MaxRows)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  bms_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: runs of always ready, coin-flip ready and long stalls
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, StallLimit);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(bms_in_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic load_row(logic [IdxW-1:0] idx, logic [RowW-1:0] bits);
    bms_in_t w;
    w.command   = CMD_LOAD;
    w.row_index = idx;
    w.row_bits  = bits;
    send_word(w);
    loaded_rows[idx] = 1'b1;
  endtask

  task automatic square_now();
    bms_in_t w;
    w.command   = CMD_SQUARE;
    w.row_index = IdxW'($urandom);
    w.row_bits  = RowW'($urandom);
    send_word(w);
  endtask

  task automatic set_size(logic [SizeW-1:0] v);
    wait_drained();
    repeat (IdleCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    rows_now = (v == '0) ? 1 : (v > MaxRows) ? MaxRows : int'(v);
  endtask

  // sparse, single-edge, dense and uniform rows
  function automatic logic [RowW-1:0] random_row();
    case ($urandom_range(0, 3))
      0:       return RowW'($urandom);
      1:       return RowW'($urandom & $urandom & $urandom);
      2:       return RowW'(1) << $urandom_range(0, RowW - 1);
      default: return RowW'(~($urandom & $urandom));
    endcase
  endfunction

  // every row in use is loaded before a square; order shuffled
  task automatic fill_rows();
    int order [MaxRows];
    int j;
    int t;
    for (int i = 0; i < rows_now; i++) order[i] = i;
    for (int i = rows_now - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < rows_now; i++) begin
      if (!loaded_rows[order[i]] || $urandom_range(0, 1)) load_row(IdxW'(order[i]), random_row());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // chain graph at full size: empty first row, full last row
    for (int r = 0; r < MaxRows; r++) begin
      load_row(IdxW'(r), (r == 0) ? '0 : (r == MaxRows - 1) ? '1 : RowW'(1) << (r + 1));
    end
    square_now();
    square_now();
    // size zero behaves as one; columns beyond it are masked
    set_size('0);
    load_row('0, RowW'(1));
    square_now();
    load_row('0, '1);
    square_now();
    // oversize saturates to full
    set_size('1);
    square_now();

    first_random = items_sent;
    while (items_sent - first_random < RandomItems) begin
      case ($urandom_range(0, 7))
        0:       set_size('0);
        1:       set_size(SizeW'(1));
        2:       set_size(SizeW'(16));
        3:       set_size('1);
        4:       set_size(SizeW'(17));
        default: set_size(SizeW'($urandom_range(2, 15)));
      endcase
      repeat ($urandom_range(1, 4)) begin
        fill_rows();
        repeat ($urandom_range(0, 2)) begin
          load_row(IdxW'($urandom_range(0, MaxRows - 1)), random_row());
        end
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 9) == 0) wait_drained();
          square_now();
        end
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bms_pkg.sv
rtl/bms_cell.sv
rtl/bms_ctrl.sv
rtl/boolean_matrix_squarer_top.sv
test/bms_checker.sv
test/testbench.sv
